[rtl/px_meta_line_tokenizer_defines.svh]
// Assertion macros used by the tokenizer top level.
`ifndef PX_META_LINE_TOKENIZER_DEFINES_SVH
`define PX_META_LINE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

[rtl/pmlt_pkg.sv]
`default_nettype none

package pmlt_pkg;

    typedef enum logic [3:0] {
        ACT_NONE     = 4'd0,
        ACT_APPEND   = 4'd1,
        ACT_DISCARD  = 4'd2,
        ACT_KEYWORD  = 4'd3,
        ACT_LANGUAGE = 4'd4,
        ACT_SUBKEY   = 4'd5,
        ACT_VALUE    = 4'd6,
        ACT_START    = 4'd7,
        ACT_START_KW = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        PH_KEYWORD  = 2'd0,
        PH_LANGUAGE = 2'd1,
        PH_SUBKEYS  = 2'd2,
        PH_VALUES   = 2'd3
    } phase_t;

    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_LBRACK_AFTER  = 4'd1;
    localparam logic [3:0] ERR_SEMI_KEYWORD  = 4'd2;
    localparam logic [3:0] ERR_RBRACK_KW     = 4'd3;
    localparam logic [3:0] ERR_RPAREN_KW     = 4'd4;
    localparam logic [3:0] ERR_WS_LANGUAGE   = 4'd5;
    localparam logic [3:0] ERR_BAD_LANGUAGE  = 4'd6;
    localparam logic [3:0] ERR_BAD_UNQUOTED  = 4'd7;
    localparam logic [3:0] ERR_OPEN_QUOTE    = 4'd8;
    localparam logic [3:0] ERR_OPEN_TIMEVAL  = 4'd9;
    localparam logic [3:0] ERR_MINUS_VALUE   = 4'd10;
    localparam logic [3:0] ERR_PENDING_VALUE = 4'd11;
    localparam logic [3:0] ERR_NO_VALUE      = 4'd12;
    localparam logic [3:0] ERR_NO_KEYWORD    = 4'd13;

    localparam logic [1:0] VK_NOT_SET  = 2'd0;
    localparam logic [1:0] VK_QUOTED   = 2'd1;
    localparam logic [1:0] VK_UNQUOTED = 2'd2;
    localparam logic [1:0] VK_ERROR    = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    localparam logic [2:0] DATA_LEN     = 3'd4;
    localparam logic [2:0] DATA_MISS    = 3'd7;
    localparam logic [3:0] TIMEVAL_LEN  = 4'd7;
    localparam logic [3:0] TIMEVAL_MISS = 4'd15;

    localparam int KF_DATA     = 0;
    localparam int KF_TIMEVAL  = 1;
    localparam int KF_NONEMPTY = 2;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       line_end;
    } in_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] char_out;
        logic [3:0] error_code;
        logic       line_done;
    } out_t;

    typedef struct packed {
        phase_t     phase;
        logic       in_quote;
        logic       saw_language;
        logic       saw_subkeys;
        logic [1:0] value_kind;
        logic       buffer_nonempty;
        logic [1:0] values_pushed;
        logic [2:0] data_match_pos;
        logic [3:0] timeval_match_pos;
        logic [2:0] keyword_flags;
        logic       halted;
    } state_t;

    localparam state_t STATE_RESET = '{phase: PH_KEYWORD, default: '0};

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [7:0] data_char(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = 8'h44;
            2'd1:    r = 8'h41;
            2'd2:    r = 8'h54;
            default: r = 8'h41;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] timeval_char(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h54;
            3'd1:    r = 8'h49;
            3'd2:    r = 8'h4D;
            3'd3:    r = 8'h45;
            3'd4:    r = 8'h56;
            3'd5:    r = 8'h41;
            3'd6:    r = 8'h4C;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/px_meta_line_tokenizer.sv]
// A byte accepted into the input register is parsed on its way to the result register.
// Throughput: one byte per cycle while results are taken; the parse state is updated when the result register loads.
// While a result waits to be taken, the input register takes one more byte, then stalls.
// Reset (rst_n low, asynchronous) returns the parse state to the start of a line
// and empties both the input and the result register.
`default_nettype none
`include "px_meta_line_tokenizer_defines.svh"

module px_meta_line_tokenizer (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 byte_valid,
    output logic                byte_stall,
    input  wire pmlt_pkg::in_t  byte_item,
    output logic                token_valid,
    input  wire                 token_stall,
    output pmlt_pkg::out_t      token_item
);

    logic             in_valid_reg;
    logic             in_valid_next;
    pmlt_pkg::in_t    in_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    pmlt_pkg::out_t   res_reg;
    pmlt_pkg::state_t state_reg;
    pmlt_pkg::state_t state_next;
    pmlt_pkg::state_t core_state;
    pmlt_pkg::out_t   core_result;
    logic             advance;
    logic             fire;
    logic             take;
    logic             res_error;
    logic             res_no_char;
    logic             line_closed;
    logic             line_fresh;

    // The result register can load when it is empty or its transaction completes.
    assign advance    = !res_valid_reg || !token_stall;
    assign fire       = in_valid_reg && advance;
    assign byte_stall = in_valid_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    pmlt_core u_core (
        .state      (state_reg),
        .item       (in_reg),
        .state_next (core_state),
        .result     (core_result)
    );

    always_comb
    begin
        in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        res_valid_next = fire ? 1'b1 : (token_stall ? res_valid_reg : 1'b0);
        state_next     = fire ? core_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= pmlt_pkg::STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= byte_item;
        if (fire)
            res_reg <= core_result;
    end

    assign token_valid = res_valid_reg;
    assign token_item  = res_reg;

    assign res_error   = res_valid_reg && res_reg.error_code != pmlt_pkg::ERR_NONE;
    assign res_no_char = res_valid_reg && res_reg.action != pmlt_pkg::ACT_APPEND;
    assign line_closed = fire && in_reg.line_end;
    assign line_fresh  = !state_reg.halted && state_reg.phase == pmlt_pkg::PH_KEYWORD
                         && state_reg.keyword_flags == 3'd0;

    `PMLT_ASSERT_IMP(a_error_ends_line, clk, rst_n, res_error, res_reg.line_done)
    `PMLT_ASSERT_IMP(a_char_only_on_append, clk, rst_n, res_no_char, res_reg.char_out == 8'd0)
    `PMLT_ASSERT_NEXT(a_line_end_resets, clk, rst_n, line_closed, line_fresh)
    `PMLT_ASSERT_NEXT(a_held_byte_kept, clk, rst_n, byte_stall, in_valid_reg && $stable(in_reg))

endmodule

`default_nettype wire

[rtl/pmlt_core.sv]
`default_nettype none

// Next-state and result logic for one byte of a metadata line.
module pmlt_core (
    input  wire pmlt_pkg::state_t state,
    input  wire pmlt_pkg::in_t    item,
    output pmlt_pkg::state_t      state_next,
    output pmlt_pkg::out_t        result
);

    function automatic pmlt_pkg::state_t buf_clear(input pmlt_pkg::state_t s);
        pmlt_pkg::state_t r;
        r = s;
        r.buffer_nonempty = 1'b0;
        r.data_match_pos = 3'd0;
        r.timeval_match_pos = 4'd0;
        return r;
    endfunction

    function automatic pmlt_pkg::state_t buf_append(input pmlt_pkg::state_t s,
                                                    input logic [7:0] c);
        pmlt_pkg::state_t r;
        r = s;
        r.buffer_nonempty = 1'b1;
        if (s.data_match_pos < pmlt_pkg::DATA_LEN
                && c == pmlt_pkg::data_char(s.data_match_pos[1:0]))
            r.data_match_pos = s.data_match_pos + 3'd1;
        else
            r.data_match_pos = pmlt_pkg::DATA_MISS;
        if (s.timeval_match_pos < pmlt_pkg::TIMEVAL_LEN
                && c == pmlt_pkg::timeval_char(s.timeval_match_pos[2:0]))
            r.timeval_match_pos = s.timeval_match_pos + 4'd1;
        else
            r.timeval_match_pos = pmlt_pkg::TIMEVAL_MISS;
        return r;
    endfunction

    function automatic pmlt_pkg::state_t take_keyword(input pmlt_pkg::state_t s);
        pmlt_pkg::state_t r;
        r = buf_clear(s);
        r.keyword_flags = {s.buffer_nonempty,
                           s.timeval_match_pos == pmlt_pkg::TIMEVAL_LEN,
                           s.data_match_pos == pmlt_pkg::DATA_LEN};
        return r;
    endfunction

    function automatic pmlt_pkg::state_t push_value(input pmlt_pkg::state_t s);
        pmlt_pkg::state_t r;
        r = buf_clear(s);
        if (s.values_pushed < 2'd2)
            r.values_pushed = s.values_pushed + 2'd1;
        return r;
    endfunction

    pmlt_pkg::state_t  ns;
    pmlt_pkg::action_t act;
    logic [3:0]        err;
    logic              done;
    logic [7:0]        c;
    logic              tv;

    always_comb
    begin
        ns   = state;
        act  = pmlt_pkg::ACT_NONE;
        err  = pmlt_pkg::ERR_NONE;
        done = item.line_end;
        c    = item.byte_in;
        tv   = state.keyword_flags[pmlt_pkg::KF_TIMEVAL];

        // Once the keyword is DATA the rest of the line is passed over.
        if (!state.halted && !state.keyword_flags[pmlt_pkg::KF_DATA])
        begin
            if (c == pmlt_pkg::CH_QUOTE)
                ns.in_quote = !state.in_quote;

            unique case (state.phase)
                pmlt_pkg::PH_KEYWORD:
                begin
                    unique case (c)
                        pmlt_pkg::CH_QUOTE:
                        begin
                        end
                        pmlt_pkg::CH_LBRACK:
                        begin
                            if (state.saw_subkeys)
                                err = pmlt_pkg::ERR_LBRACK_AFTER;
                            else
                            begin
                                ns = take_keyword(ns);
                                act = pmlt_pkg::ACT_KEYWORD;
                                ns.phase = pmlt_pkg::PH_LANGUAGE;
                                ns.saw_language = 1'b1;
                            end
                        end
                        pmlt_pkg::CH_LPAREN:
                        begin
                            if (!state.saw_language)
                            begin
                                ns = take_keyword(ns);
                                act = pmlt_pkg::ACT_KEYWORD;
                            end
                            else
                            begin
                                ns = buf_clear(ns);
                                act = pmlt_pkg::ACT_DISCARD;
                            end
                            ns.phase = pmlt_pkg::PH_SUBKEYS;
                            ns.saw_subkeys = 1'b1;
                        end
                        pmlt_pkg::CH_EQUAL:
                        begin
                            if (!(state.saw_subkeys || state.saw_language))
                            begin
                                ns = take_keyword(ns);
                                act = pmlt_pkg::ACT_START_KW;
                            end
                            else
                            begin
                                ns = buf_clear(ns);
                                act = pmlt_pkg::ACT_START;
                            end
                            ns.values_pushed = 2'd0;
                            ns.phase = pmlt_pkg::PH_VALUES;
                        end
                        pmlt_pkg::CH_SEMI:   err = pmlt_pkg::ERR_SEMI_KEYWORD;
                        pmlt_pkg::CH_RBRACK: err = pmlt_pkg::ERR_RBRACK_KW;
                        pmlt_pkg::CH_RPAREN: err = pmlt_pkg::ERR_RPAREN_KW;
                        default:
                        begin
                            if (ns.in_quote || !pmlt_pkg::is_ws(c))
                            begin
                                ns = buf_append(ns, c);
                                act = pmlt_pkg::ACT_APPEND;
                            end
                        end
                    endcase
                end

                pmlt_pkg::PH_LANGUAGE:
                begin
                    priority if (pmlt_pkg::is_ws(c))
                        err = pmlt_pkg::ERR_WS_LANGUAGE;
                    else if (c == pmlt_pkg::CH_EQUAL || c == pmlt_pkg::CH_LPAREN
                             || c == pmlt_pkg::CH_LBRACK || c == pmlt_pkg::CH_SEMI
                             || c == pmlt_pkg::CH_RPAREN || c == pmlt_pkg::CH_QUOTE)
                        err = pmlt_pkg::ERR_BAD_LANGUAGE;
                    else if (c == pmlt_pkg::CH_RBRACK)
                    begin
                        ns = buf_clear(ns);
                        act = pmlt_pkg::ACT_LANGUAGE;
                        ns.phase = pmlt_pkg::PH_KEYWORD;
                    end
                    else
                    begin
                        ns = buf_append(ns, c);
                        act = pmlt_pkg::ACT_APPEND;
                    end
                end

                pmlt_pkg::PH_SUBKEYS:
                begin
                    priority if (c == pmlt_pkg::CH_QUOTE)
                    begin
                    end
                    else if ((c == pmlt_pkg::CH_COMMA || c == pmlt_pkg::CH_RPAREN)
                             && ns.in_quote)
                    begin
                        ns = buf_append(ns, c);
                        act = pmlt_pkg::ACT_APPEND;
                    end
                    else if (c == pmlt_pkg::CH_COMMA)
                    begin
                        ns = buf_clear(ns);
                        act = pmlt_pkg::ACT_SUBKEY;
                    end
                    else if (c == pmlt_pkg::CH_RPAREN)
                    begin
                        // An empty subkey before the closing parenthesis is not pushed.
                        if (state.buffer_nonempty)
                        begin
                            ns = buf_clear(ns);
                            act = pmlt_pkg::ACT_SUBKEY;
                        end
                        ns.phase = pmlt_pkg::PH_KEYWORD;
                    end
                    else if (ns.in_quote || !pmlt_pkg::is_ws(c))
                    begin
                        ns = buf_append(ns, c);
                        act = pmlt_pkg::ACT_APPEND;
                    end
                    else
                    begin
                        // Whitespace outside quotes is dropped.
                    end
                end

                default:
                begin
                    priority if (state.values_pushed != 2'd0
                                 && state.value_kind == pmlt_pkg::VK_ERROR)
                    begin
                        if (c == pmlt_pkg::CH_SEMI)
                            err = pmlt_pkg::ERR_PENDING_VALUE;
                    end
                    else if (ns.in_quote)
                    begin
                        priority if (state.value_kind == pmlt_pkg::VK_NOT_SET)
                        begin
                            ns.value_kind = pmlt_pkg::VK_QUOTED;
                            if (c != pmlt_pkg::CH_QUOTE)
                            begin
                                ns = buf_append(ns, c);
                                act = pmlt_pkg::ACT_APPEND;
                            end
                        end
                        else if (state.value_kind == pmlt_pkg::VK_QUOTED)
                        begin
                            priority if (c == pmlt_pkg::CH_QUOTE)
                            begin
                            end
                            else if (c == pmlt_pkg::CH_SEMI
                                     && state.values_pushed >= 2'd2)
                                err = pmlt_pkg::ERR_OPEN_QUOTE;
                            else if (tv && c == pmlt_pkg::CH_SEMI
                                     && state.values_pushed != 2'd0)
                                err = pmlt_pkg::ERR_OPEN_TIMEVAL;
                            else
                            begin
                                ns = buf_append(ns, c);
                                act = pmlt_pkg::ACT_APPEND;
                            end
                        end
                        else
                            ns.value_kind = pmlt_pkg::VK_ERROR;
                    end
                    else if (pmlt_pkg::is_ws(c) || c == pmlt_pkg::CH_QUOTE)
                    begin
                    end
                    else
                    begin
                        unique case (c)
                            pmlt_pkg::CH_LBRACK, pmlt_pkg::CH_EQUAL, pmlt_pkg::CH_RBRACK:
                                err = pmlt_pkg::ERR_BAD_UNQUOTED;
                            pmlt_pkg::CH_COMMA:
                            begin
                                ns = push_value(ns);
                                act = pmlt_pkg::ACT_VALUE;
                                ns.value_kind = pmlt_pkg::VK_NOT_SET;
                            end
                            pmlt_pkg::CH_COLON:
                            begin
                                ns = buf_append(ns, c);
                                act = pmlt_pkg::ACT_APPEND;
                            end
                            pmlt_pkg::CH_MINUS:
                            begin
                                if (!tv)
                                    err = pmlt_pkg::ERR_MINUS_VALUE;
                                else
                                begin
                                    ns = buf_append(ns, c);
                                    act = pmlt_pkg::ACT_APPEND;
                                end
                            end
                            pmlt_pkg::CH_RPAREN:
                            begin
                                if (tv)
                                begin
                                    ns = buf_append(ns, c);
                                    act = pmlt_pkg::ACT_APPEND;
                                end
                                else
                                    ns.value_kind = pmlt_pkg::VK_ERROR;
                            end
                            pmlt_pkg::CH_SEMI:
                            begin
                                ns = push_value(ns);
                                act = pmlt_pkg::ACT_VALUE;
                            end
                            default:
                            begin
                                // Only the first unquoted value keeps its characters.
                                if (state.value_kind == pmlt_pkg::VK_NOT_SET
                                        || state.value_kind == pmlt_pkg::VK_UNQUOTED)
                                begin
                                    ns.value_kind = pmlt_pkg::VK_UNQUOTED;
                                    if (state.values_pushed == 2'd0)
                                    begin
                                        ns = buf_append(ns, c);
                                        act = pmlt_pkg::ACT_APPEND;
                                    end
                                end
                                else if (state.value_kind == pmlt_pkg::VK_QUOTED)
                                    ns.value_kind = pmlt_pkg::VK_ERROR;
                            end
                        endcase
                    end
                end
            endcase

            if (err != pmlt_pkg::ERR_NONE)
            begin
                ns.halted = 1'b1;
                act = pmlt_pkg::ACT_NONE;
                done = 1'b1;
            end
        end

        // End-of-line checks look at the state left by this byte.
        if (item.line_end && !state.halted && err == pmlt_pkg::ERR_NONE)
        begin
            if (ns.values_pushed == 2'd0 && !ns.keyword_flags[pmlt_pkg::KF_DATA])
                err = pmlt_pkg::ERR_NO_VALUE;
            else if (!ns.keyword_flags[pmlt_pkg::KF_NONEMPTY])
                err = pmlt_pkg::ERR_NO_KEYWORD;
        end

        if (item.line_end)
            ns = pmlt_pkg::STATE_RESET;
    end

    assign state_next        = ns;
    assign result.action     = act;
    assign result.char_out   = (act == pmlt_pkg::ACT_APPEND) ? c : 8'd0;
    assign result.error_code = err;
    assign result.line_done  = done;

endmodule

`default_nettype wire

[dv/px_meta_line_tokenizer_tb.sv]
`timescale 1ns / 100ps

module px_meta_line_tokenizer_tb;

    localparam int HOLD_LEN    = 300;
    localparam int QUIET_LIMIT = 2000;

    localparam logic [31:0] KEY_DATA    = "DATA";
    localparam logic [55:0] KEY_TIMEVAL = "TIMEVAL";

    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic byte_valid  = 1'b0;
    logic byte_stall;
    pmlt_pkg::in_t  byte_item = '0;
    logic token_valid;
    logic token_stall = 1'b0;
    pmlt_pkg::out_t token_item;

    pmlt_pkg::in_t    line_bytes[$];
    pmlt_pkg::out_t   pending_tokens[$];
    logic [7:0]       line_buf[$];
    pmlt_pkg::state_t tok_st = pmlt_pkg::STATE_RESET;
    int          bytes_queued  = 0;
    int          mismatches    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles  = 0;
    int          hold_cycles   = 0;
    logic        hold_req      = 1'b0;

    px_meta_line_tokenizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_item   (byte_item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic is_space_char(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void clear_buffer();
        tok_st.buffer_nonempty   = 1'b0;
        tok_st.data_match_pos    = '0;
        tok_st.timeval_match_pos = '0;
    endfunction

    // Appends to the consumer's buffer and advances the keyword trackers.
    function automatic void note_char(input logic [7:0] c);
        int dp;
        int tp;
        dp = tok_st.data_match_pos;
        tp = tok_st.timeval_match_pos;
        tok_st.buffer_nonempty = 1'b1;
        if (dp < 4 && c == KEY_DATA[31 - 8 * dp -: 8])
            tok_st.data_match_pos = tok_st.data_match_pos + 3'd1;
        else
            tok_st.data_match_pos = pmlt_pkg::DATA_MISS;
        if (tp < 7 && c == KEY_TIMEVAL[55 - 8 * tp -: 8])
            tok_st.timeval_match_pos = tok_st.timeval_match_pos + 4'd1;
        else
            tok_st.timeval_match_pos = pmlt_pkg::TIMEVAL_MISS;
    endfunction

    function automatic void take_keyword();
        tok_st.keyword_flags = '0;
        tok_st.keyword_flags[pmlt_pkg::KF_DATA] =
            (tok_st.data_match_pos == pmlt_pkg::DATA_LEN);
        tok_st.keyword_flags[pmlt_pkg::KF_TIMEVAL] =
            (tok_st.timeval_match_pos == pmlt_pkg::TIMEVAL_LEN);
        tok_st.keyword_flags[pmlt_pkg::KF_NONEMPTY] = tok_st.buffer_nonempty;
        clear_buffer();
    endfunction

    function automatic void store_value();
        if (tok_st.values_pushed < 2'd2)
            tok_st.values_pushed = tok_st.values_pushed + 2'd1;
        clear_buffer();
    endfunction

    function automatic logic [3:0] parse_byte(input logic [7:0] c,
                                              output pmlt_pkg::action_t act);
        logic tv;
        tv  = tok_st.keyword_flags[pmlt_pkg::KF_TIMEVAL];
        act = pmlt_pkg::ACT_NONE;
        case (tok_st.phase)
            pmlt_pkg::PH_KEYWORD:
            begin
                case (c)
                    pmlt_pkg::CH_QUOTE: ;
                    pmlt_pkg::CH_LBRACK:
                    begin
                        if (tok_st.saw_subkeys)
                            return pmlt_pkg::ERR_LBRACK_AFTER;
                        take_keyword();
                        act = pmlt_pkg::ACT_KEYWORD;
                        tok_st.phase = pmlt_pkg::PH_LANGUAGE;
                        tok_st.saw_language = 1'b1;
                    end
                    pmlt_pkg::CH_LPAREN:
                    begin
                        if (!tok_st.saw_language)
                        begin
                            take_keyword();
                            act = pmlt_pkg::ACT_KEYWORD;
                        end
                        else
                        begin
                            clear_buffer();
                            act = pmlt_pkg::ACT_DISCARD;
                        end
                        tok_st.phase = pmlt_pkg::PH_SUBKEYS;
                        tok_st.saw_subkeys = 1'b1;
                    end
                    pmlt_pkg::CH_EQUAL:
                    begin
                        if (!(tok_st.saw_subkeys || tok_st.saw_language))
                        begin
                            take_keyword();
                            act = pmlt_pkg::ACT_START_KW;
                        end
                        else
                        begin
                            clear_buffer();
                            act = pmlt_pkg::ACT_START;
                        end
                        tok_st.values_pushed = '0;
                        tok_st.phase = pmlt_pkg::PH_VALUES;
                    end
                    pmlt_pkg::CH_SEMI:   return pmlt_pkg::ERR_SEMI_KEYWORD;
                    pmlt_pkg::CH_RBRACK: return pmlt_pkg::ERR_RBRACK_KW;
                    pmlt_pkg::CH_RPAREN: return pmlt_pkg::ERR_RPAREN_KW;
                    default:
                    begin
                        if (tok_st.in_quote || !is_space_char(c))
                        begin
                            note_char(c);
                            act = pmlt_pkg::ACT_APPEND;
                        end
                    end
                endcase
            end
            pmlt_pkg::PH_LANGUAGE:
            begin
                if (is_space_char(c))
                    return pmlt_pkg::ERR_WS_LANGUAGE;
                case (c)
                    pmlt_pkg::CH_EQUAL, pmlt_pkg::CH_LPAREN, pmlt_pkg::CH_LBRACK,
                    pmlt_pkg::CH_SEMI, pmlt_pkg::CH_RPAREN, pmlt_pkg::CH_QUOTE:
                        return pmlt_pkg::ERR_BAD_LANGUAGE;
                    pmlt_pkg::CH_RBRACK:
                    begin
                        clear_buffer();
                        act = pmlt_pkg::ACT_LANGUAGE;
                        tok_st.phase = pmlt_pkg::PH_KEYWORD;
                    end
                    default:
                    begin
                        note_char(c);
                        act = pmlt_pkg::ACT_APPEND;
                    end
                endcase
            end
            pmlt_pkg::PH_SUBKEYS:
            begin
                if (c == pmlt_pkg::CH_QUOTE)
                begin
                end
                else if ((c == pmlt_pkg::CH_COMMA || c == pmlt_pkg::CH_RPAREN)
                         && tok_st.in_quote)
                begin
                    note_char(c);
                    act = pmlt_pkg::ACT_APPEND;
                end
                else if (c == pmlt_pkg::CH_COMMA)
                begin
                    clear_buffer();
                    act = pmlt_pkg::ACT_SUBKEY;
                end
                else if (c == pmlt_pkg::CH_RPAREN)
                begin
                    // An empty subkey is not pushed.
                    if (tok_st.buffer_nonempty)
                    begin
                        clear_buffer();
                        act = pmlt_pkg::ACT_SUBKEY;
                    end
                    tok_st.phase = pmlt_pkg::PH_KEYWORD;
                end
                else if (tok_st.in_quote || !is_space_char(c))
                begin
                    note_char(c);
                    act = pmlt_pkg::ACT_APPEND;
                end
            end
            default:
            begin
                if (tok_st.values_pushed != 2'd0 && tok_st.value_kind == pmlt_pkg::VK_ERROR)
                begin
                    if (c == pmlt_pkg::CH_SEMI)
                        return pmlt_pkg::ERR_PENDING_VALUE;
                end
                else if (tok_st.in_quote)
                begin
                    if (tok_st.value_kind == pmlt_pkg::VK_NOT_SET)
                    begin
                        tok_st.value_kind = pmlt_pkg::VK_QUOTED;
                        if (c != pmlt_pkg::CH_QUOTE)
                        begin
                            note_char(c);
                            act = pmlt_pkg::ACT_APPEND;
                        end
                    end
                    else if (tok_st.value_kind == pmlt_pkg::VK_QUOTED)
                    begin
                        if (c != pmlt_pkg::CH_QUOTE)
                        begin
                            if (c == pmlt_pkg::CH_SEMI && tok_st.values_pushed >= 2'd2)
                                return pmlt_pkg::ERR_OPEN_QUOTE;
                            if (tv && c == pmlt_pkg::CH_SEMI && tok_st.values_pushed != 2'd0)
                                return pmlt_pkg::ERR_OPEN_TIMEVAL;
                            note_char(c);
                            act = pmlt_pkg::ACT_APPEND;
                        end
                    end
                    else
                        tok_st.value_kind = pmlt_pkg::VK_ERROR;
                end
                else if (is_space_char(c) || c == pmlt_pkg::CH_QUOTE)
                begin
                end
                else
                begin
                    case (c)
                        pmlt_pkg::CH_LBRACK, pmlt_pkg::CH_EQUAL, pmlt_pkg::CH_RBRACK:
                            return pmlt_pkg::ERR_BAD_UNQUOTED;
                        pmlt_pkg::CH_COMMA:
                        begin
                            store_value();
                            act = pmlt_pkg::ACT_VALUE;
                            tok_st.value_kind = pmlt_pkg::VK_NOT_SET;
                        end
                        pmlt_pkg::CH_COLON:
                        begin
                            note_char(c);
                            act = pmlt_pkg::ACT_APPEND;
                        end
                        pmlt_pkg::CH_MINUS:
                        begin
                            if (!tv)
                                return pmlt_pkg::ERR_MINUS_VALUE;
                            note_char(c);
                            act = pmlt_pkg::ACT_APPEND;
                        end
                        pmlt_pkg::CH_RPAREN:
                        begin
                            if (tv)
                            begin
                                note_char(c);
                                act = pmlt_pkg::ACT_APPEND;
                            end
                            else
                                tok_st.value_kind = pmlt_pkg::VK_ERROR;
                        end
                        pmlt_pkg::CH_SEMI:
                        begin
                            store_value();
                            act = pmlt_pkg::ACT_VALUE;
                        end
                        default:
                        begin
                            // Unquoted values after the first are dropped.
                            if (tok_st.value_kind == pmlt_pkg::VK_NOT_SET
                                || tok_st.value_kind == pmlt_pkg::VK_UNQUOTED)
                            begin
                                tok_st.value_kind = pmlt_pkg::VK_UNQUOTED;
                                if (tok_st.values_pushed == 2'd0)
                                begin
                                    note_char(c);
                                    act = pmlt_pkg::ACT_APPEND;
                                end
                            end
                            else if (tok_st.value_kind == pmlt_pkg::VK_QUOTED)
                                tok_st.value_kind = pmlt_pkg::VK_ERROR;
                        end
                    endcase
                end
            end
        endcase
        return pmlt_pkg::ERR_NONE;
    endfunction

    function automatic pmlt_pkg::out_t tokenize(input pmlt_pkg::in_t it);
        pmlt_pkg::out_t    r;
        pmlt_pkg::action_t act;
        logic [3:0]        err;
        logic              was_halted;
        act        = pmlt_pkg::ACT_NONE;
        err        = pmlt_pkg::ERR_NONE;
        was_halted = tok_st.halted;
        r.line_done = it.line_end;
        // Once the keyword is DATA the rest of the line is ignored.
        if (!was_halted && !tok_st.keyword_flags[pmlt_pkg::KF_DATA])
        begin
            if (it.byte_in == pmlt_pkg::CH_QUOTE)
                tok_st.in_quote = ~tok_st.in_quote;
            err = parse_byte(it.byte_in, act);
            if (err != pmlt_pkg::ERR_NONE)
            begin
                tok_st.halted = 1'b1;
                act = pmlt_pkg::ACT_NONE;
                r.line_done = 1'b1;
            end
        end
        if (it.line_end && !was_halted && err == pmlt_pkg::ERR_NONE)
        begin
            if (tok_st.values_pushed == 2'd0 && !tok_st.keyword_flags[pmlt_pkg::KF_DATA])
                err = pmlt_pkg::ERR_NO_VALUE;
            else if (!tok_st.keyword_flags[pmlt_pkg::KF_NONEMPTY])
                err = pmlt_pkg::ERR_NO_KEYWORD;
        end
        r.action     = act;
        r.char_out   = (act == pmlt_pkg::ACT_APPEND) ? it.byte_in : 8'h00;
        r.error_code = err;
        if (it.line_end)
            tok_st = pmlt_pkg::STATE_RESET;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    // Sender: the expected result is computed when a transaction is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                pending_tokens = {pending_tokens, tokenize(byte_item)};
            if (!byte_valid || !byte_stall)
            begin
                if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_item  <= line_bytes.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each accepted transaction and decides the next stall.
    always @(posedge clk)
    begin : token_monitor
        pmlt_pkg::out_t want;
        if (rst_n)
        begin
            if (token_valid && !token_stall)
            begin
                if (pending_tokens.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = pending_tokens.pop_front();
                    if (token_item.action !== want.action)
                        report_mismatch("action", token_item.action, want.action);
                    if (token_item.char_out !== want.char_out)
                        report_mismatch("char_out", token_item.char_out, want.char_out);
                    if (token_item.error_code !== want.error_code)
                        report_mismatch("error_code", token_item.error_code,
                                        want.error_code);
                    if (token_item.line_done !== want.line_done)
                        report_mismatch("line_done", token_item.line_done, want.line_done);
                end
            end
            if (hold_req && hold_cycles < HOLD_LEN)
            begin
                hold_cycles <= hold_cycles + 1;
                token_stall <= 1'b1;
            end
            else
                token_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (token_valid && !token_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", pending_tokens.size());
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic add_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // Moves the assembled line to the sender, marking its last byte.
    task automatic flush_line();
        pmlt_pkg::in_t it;
        foreach (line_buf[i])
        begin
            it.byte_in  = line_buf[i];
            it.line_end = (i == line_buf.size() - 1);
            line_bytes = {line_bytes, it};
        end
        bytes_queued += line_buf.size();
        line_buf.delete();
    endtask

    task automatic send_text(input string s);
        add_text(s);
        flush_line();
    endtask

    function automatic logic [7:0] plain_char();
        case ($urandom_range(3))
            0:       return 8'(8'h41 + $urandom_range(25));
            1:       return 8'(8'h61 + $urandom_range(25));
            2:       return 8'(8'h30 + $urandom_range(9));
            default: return 8'(8'h80 + $urandom_range(127));
        endcase
    endfunction

    function automatic logic [7:0] punct_char();
        case ($urandom_range(11))
            0:       return pmlt_pkg::CH_QUOTE;
            1:       return pmlt_pkg::CH_LBRACK;
            2:       return pmlt_pkg::CH_RBRACK;
            3:       return pmlt_pkg::CH_LPAREN;
            4:       return pmlt_pkg::CH_RPAREN;
            5:       return pmlt_pkg::CH_EQUAL;
            6:       return pmlt_pkg::CH_SEMI;
            7:       return pmlt_pkg::CH_COMMA;
            8:       return pmlt_pkg::CH_COLON;
            9:       return pmlt_pkg::CH_MINUS;
            10:      return 8'd32;
            default: return 8'(8'd9 + $urandom_range(4));
        endcase
    endfunction

    // Quoted text may hold separators.
    task automatic add_quoted();
        add_text("\"");
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(5))
                0:       add_byte(pmlt_pkg::CH_SEMI);
                1:       add_byte(pmlt_pkg::CH_COMMA);
                2:       add_byte(pmlt_pkg::CH_RPAREN);
                3:       add_byte(8'd32);
                default: add_byte(plain_char());
            endcase
        end
        add_text("\"");
    endtask

    task automatic build_line();
        int n;
        int i;
        if ($urandom_range(99) < 75)
        begin
            case ($urandom_range(9))
                0, 1:    add_text("TIMEVAL");
                2:       add_text("DATA");
                3:       ;
                default: repeat ($urandom_range(1, 6)) add_byte(plain_char());
            endcase
            if ($urandom_range(9) < 3)
            begin
                add_text("[");
                repeat ($urandom_range(1, 3)) add_byte(plain_char());
                add_text("]");
            end
            if ($urandom_range(9) < 4)
            begin
                add_text("(");
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                begin
                    if (i > 0)
                        add_text(",");
                    if ($urandom_range(1))
                        add_quoted();
                    else
                        repeat ($urandom_range(1, 4)) add_byte(plain_char());
                end
                add_text(")");
            end
            add_text("=");
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                if (i > 0)
                    add_text(",");
                if ($urandom_range(1))
                    add_quoted();
                else
                    repeat ($urandom_range(1, 5))
                    begin
                        case ($urandom_range(9))
                            0:       add_byte(pmlt_pkg::CH_COLON);
                            1:       add_byte(pmlt_pkg::CH_MINUS);
                            2:       add_byte(pmlt_pkg::CH_RPAREN);
                            3:       add_byte(8'd32);
                            default: add_byte(plain_char());
                        endcase
                    end
            end
            if ($urandom_range(9) < 8)
                add_text(";");
            if ($urandom_range(3) == 0)
                add_text(" ");
            // Now and then a broken line: one byte replaced by punctuation.
            if ($urandom_range(9) == 0)
                line_buf[$urandom_range(line_buf.size() - 1)] = punct_char();
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                add_byte($urandom_range(1) ? punct_char() : 8'($urandom_range(255)));
        end
        flush_line();
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (line_bytes.size() != 0 || byte_valid || pending_tokens.size() != 0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 32;
        recv_idle_pct = 77;

        // Byte extremes, every action and every error code but the open-quote and open-timeval ones.
        add_byte(8'hFF);
        add_byte(8'h00);
        flush_line();
        send_text("()[");
        send_text(";");
        send_text("]");
        send_text(")");
        send_text("[ ");
        send_text("[=");
        send_text("=[");
        send_text("=-");
        send_text("=1,);");
        send_text("[e](s)=1;");

        while (bytes_queued < 240)
            build_line();
        wait_idle();

        send_idle_pct = 77;
        recv_idle_pct = 32;
        while (bytes_queued < 440)
            build_line();
        wait_idle();

        // The receiver holds off while the sender keeps offering.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        while (bytes_queued < 650)
            build_line();
        while (hold_cycles < HOLD_LEN)
            @(negedge clk);
        hold_req = 1'b0;
        wait_idle();

        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[px_meta_line_tokenizer.f]
+incdir+rtl
rtl/pmlt_pkg.sv
rtl/pmlt_core.sv
rtl/px_meta_line_tokenizer.sv
dv/px_meta_line_tokenizer_tb.sv
